/* hw/rtl/rprs_pkg.sv */
// Shared types and constants for the row profile run segmenter.
package rprs_pkg;

    localparam int MaxLinePixels = 4096;
    localparam int MaxLines      = 4096;

    localparam int CntW  = 13;
    localparam int LineW = 12;
    localparam int RunW  = 12;
    localparam int GrayW = 8;
    localparam int FillW = 9;
    localparam int LhsW  = CntW + 8;
    localparam int RhsW  = CntW + FillW;

    localparam logic [CntW-1:0] CntCap =
        CntW'((MaxLinePixels < 8191) ? MaxLinePixels : 8191);
    localparam logic [LineW-1:0] LineCap = LineW'(MaxLines - 1);
    localparam logic [RunW-1:0]  RunCap  = {RunW{1'b1}};

    localparam int AddrW = 4;
    localparam int DataW = 32;

    typedef enum logic [1:0] {
        REG_BLACK_THRESHOLD = 2'd0,
        REG_FILL_FRACTION   = 2'd1,
        REG_GAP_LIMIT       = 2'd2,
        REG_START_INDEX     = 2'd3
    } reg_idx_t;

    localparam logic [GrayW-1:0] BlackThresholdRst = 8'd128;
    localparam logic [FillW-1:0] FillFractionRst   = 9'd26;
    localparam logic [LineW-1:0] GapLimitRst       = 12'd2;
    localparam logic [LineW-1:0] StartIndexRst     = 12'd0;

    typedef struct packed {
        logic [GrayW-1:0] black_threshold;
        logic [FillW-1:0] fill_fraction_q8;
        logic [LineW-1:0] gap_limit;
        logic [LineW-1:0] start_index;
    } cfg_t;

endpackage

/* hw/rtl/rprs_pix_if.sv */
// Pixel item channel.
interface rprs_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rprs_pkg::GrayW-1:0] pixel_gray;
    logic                       line_end;
    logic                       scan_end;

    modport source (output valid, output pixel_gray, output line_end, output scan_end,
                    input ready);
    modport sink   (input valid, input pixel_gray, input line_end, input scan_end,
                    output ready);
endinterface

/* hw/rtl/rprs_run_if.sv */
// Run result item channel.
interface rprs_run_if;
    logic                      valid;
    logic                      ready;
    logic [rprs_pkg::LineW-1:0] run_first;
    logic [rprs_pkg::LineW-1:0] run_last;
    logic [rprs_pkg::RunW-1:0]  run_number;

    modport source (output valid, output run_first, output run_last, output run_number,
                    input ready);
    modport sink   (input valid, input run_first, input run_last, input run_number,
                    output ready);
endinterface

/* hw/rtl/row_profile_run_segmenter.sv */
// Row profile run segmenter: top level with line classifier and run tracker.
//
//   channel | dir | handshake     | payload
//   pix     | in  | valid/ready   | pixel_gray[7:0], line_end, scan_end
//   run     | out | valid/ready   | run_first[11:0], run_last[11:0], run_number[11:0]
//   apb     | in  | psel/penable  | paddr[3:0], pwdata/prdata[31:0], pready tied high
//
// One pixel item per cycle sustained while run is not stalled; a run item leaves
// after the pixel that closes it via the input register, then the result register.
// The input register advances whenever the result register is empty or being taken,
// so a stalled run output holds one pixel in the input register and then stalls pix.
// Reset clears counts, run state and line index (to start_index reset value).
module row_profile_run_segmenter (
    input  logic                          clk,
    input  logic                          rst_n,
    rprs_pix_if.sink                      pix,
    rprs_run_if.source                    run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rprs_pkg::AddrW-1:0]    paddr,
    input  logic [rprs_pkg::DataW-1:0]    pwdata,
    output logic [rprs_pkg::DataW-1:0]    prdata,
    output logic                          pready
);

    rprs_pkg::cfg_t cfg;

    rprs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic                       in_valid_reg;
    logic [rprs_pkg::GrayW-1:0] gray_reg;
    logic                       eol_reg;
    logic                       eos_reg;

    // per-scan state
    logic [rprs_pkg::CntW-1:0]  black_cnt_reg, black_cnt_next;
    logic [rprs_pkg::CntW-1:0]  pix_cnt_reg, pix_cnt_next;
    logic [rprs_pkg::LineW-1:0] line_idx_reg, line_idx_next;
    logic                       in_run_reg, in_run_next;
    logic [rprs_pkg::LineW-1:0] run_begin_reg, run_begin_next;
    logic [rprs_pkg::LineW-1:0] last_dark_reg, last_dark_next;
    logic [rprs_pkg::RunW-1:0]  runs_reg, runs_next;

    // result register
    logic                       out_valid_reg;
    logic [rprs_pkg::LineW-1:0] out_first_reg;
    logic [rprs_pkg::LineW-1:0] out_last_reg;
    logic [rprs_pkg::RunW-1:0]  out_num_reg;

    logic                       out_free;
    logic                       advance;
    logic                       line_done;
    logic [rprs_pkg::CntW-1:0]  black_cnt_inc;
    logic [rprs_pkg::CntW-1:0]  pix_cnt_inc;
    logic [rprs_pkg::LhsW:0]    lhs;
    logic [rprs_pkg::RhsW-1:0]  rhs;
    logic                       dark;
    logic [rprs_pkg::LineW-1:0] gap_len;
    logic                       emit_gap;
    logic                       emit;
    logic                       in_run_mid;
    logic [rprs_pkg::LineW-1:0] run_begin_mid;
    logic [rprs_pkg::LineW-1:0] last_dark_mid;

    assign out_free  = !out_valid_reg || run.ready;
    assign advance   = in_valid_reg && out_free;
    assign pix.ready = !in_valid_reg || out_free;

    assign run.valid      = out_valid_reg;
    assign run.run_first  = out_first_reg;
    assign run.run_last   = out_last_reg;
    assign run.run_number = out_num_reg;

    always_comb
    begin
        line_done = eol_reg || eos_reg;

        black_cnt_inc = black_cnt_reg;
        if ((gray_reg < cfg.black_threshold) && (black_cnt_reg < rprs_pkg::CntCap))
        begin
            black_cnt_inc = black_cnt_reg + 1'b1;
        end
        pix_cnt_inc = pix_cnt_reg;
        if (pix_cnt_reg < rprs_pkg::CntCap)
        begin
            pix_cnt_inc = pix_cnt_reg + 1'b1;
        end

        // black*256 > fill*pixels
        lhs  = {1'b0, black_cnt_inc, 8'd0};
        rhs  = rprs_pkg::RhsW'(cfg.fill_fraction_q8) * rprs_pkg::RhsW'(pix_cnt_inc);
        dark = rprs_pkg::RhsW'(lhs) > rhs;

        gap_len  = line_idx_reg - last_dark_reg;
        emit_gap = line_done && !dark && in_run_reg && (line_idx_reg >= last_dark_reg)
                   && (gap_len > cfg.gap_limit);

        in_run_mid    = in_run_reg;
        run_begin_mid = run_begin_reg;
        last_dark_mid = last_dark_reg;
        if (line_done && dark)
        begin
            in_run_mid    = 1'b1;
            last_dark_mid = line_idx_reg;
            if (!in_run_reg)
            begin
                run_begin_mid = line_idx_reg;
            end
        end
        else if (emit_gap)
        begin
            in_run_mid = 1'b0;
        end

        emit = emit_gap || (eos_reg && in_run_mid);

        black_cnt_next = line_done ? '0 : black_cnt_inc;
        pix_cnt_next   = line_done ? '0 : pix_cnt_inc;
        line_idx_next  = line_idx_reg;
        if (line_done && (line_idx_reg < rprs_pkg::LineCap))
        begin
            line_idx_next = line_idx_reg + 1'b1;
        end
        in_run_next    = in_run_mid && !emit;
        run_begin_next = run_begin_mid;
        last_dark_next = last_dark_mid;
        runs_next      = runs_reg;
        if (emit && (runs_reg < rprs_pkg::RunCap))
        begin
            runs_next = runs_reg + 1'b1;
        end

        if (eos_reg)
        begin
            line_idx_next  = (cfg.start_index > rprs_pkg::LineCap) ? rprs_pkg::LineCap
                                                                   : cfg.start_index;
            in_run_next    = 1'b0;
            run_begin_next = '0;
            last_dark_next = '0;
            runs_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            black_cnt_reg <= '0;
            pix_cnt_reg   <= '0;
            line_idx_reg  <= rprs_pkg::StartIndexRst;
            in_run_reg    <= 1'b0;
            run_begin_reg <= '0;
            last_dark_reg <= '0;
            runs_reg      <= '0;
        end
        else
        begin
            if (pix.ready)
            begin
                in_valid_reg <= pix.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
            if (advance)
            begin
                black_cnt_reg <= black_cnt_next;
                pix_cnt_reg   <= pix_cnt_next;
                line_idx_reg  <= line_idx_next;
                in_run_reg    <= in_run_next;
                run_begin_reg <= run_begin_next;
                last_dark_reg <= last_dark_next;
                runs_reg      <= runs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            gray_reg <= pix.pixel_gray;
            eol_reg  <= pix.line_end;
            eos_reg  <= pix.scan_end;
        end
        if (advance && emit)
        begin
            out_first_reg <= run_begin_mid;
            out_last_reg  <= last_dark_mid;
            out_num_reg   <= runs_reg;
        end
    end

endmodule

/* hw/rtl/rprs_cfg_regs.sv */
// APB configuration registers.
module rprs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rprs_pkg::AddrW-1:0]    paddr,
    input  logic [rprs_pkg::DataW-1:0]    pwdata,
    output logic [rprs_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    output rprs_pkg::cfg_t                cfg
);

    rprs_pkg::cfg_t   cfg_reg;
    rprs_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = rprs_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_threshold  <= rprs_pkg::BlackThresholdRst;
            cfg_reg.fill_fraction_q8 <= rprs_pkg::FillFractionRst;
            cfg_reg.gap_limit        <= rprs_pkg::GapLimitRst;
            cfg_reg.start_index      <= rprs_pkg::StartIndexRst;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rprs_pkg::REG_BLACK_THRESHOLD:
                    cfg_reg.black_threshold  <= pwdata[rprs_pkg::GrayW-1:0];
                rprs_pkg::REG_FILL_FRACTION:
                    cfg_reg.fill_fraction_q8 <= pwdata[rprs_pkg::FillW-1:0];
                rprs_pkg::REG_GAP_LIMIT:
                    cfg_reg.gap_limit        <= pwdata[rprs_pkg::LineW-1:0];
                rprs_pkg::REG_START_INDEX:
                    cfg_reg.start_index      <= pwdata[rprs_pkg::LineW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            rprs_pkg::REG_BLACK_THRESHOLD:
                prdata = rprs_pkg::DataW'(cfg_reg.black_threshold);
            rprs_pkg::REG_FILL_FRACTION:
                prdata = rprs_pkg::DataW'(cfg_reg.fill_fraction_q8);
            rprs_pkg::REG_GAP_LIMIT:
                prdata = rprs_pkg::DataW'(cfg_reg.gap_limit);
            rprs_pkg::REG_START_INDEX:
                prdata = rprs_pkg::DataW'(cfg_reg.start_index);
            default: prdata = '0;
        endcase
    end

endmodule

/* bench/tb_row_profile_run_segmenter.sv */
`timescale 1ns / 100ps
// Testbench for row_profile_run_segmenter: directed and random scans checked against a predictor.
module tb_row_profile_run_segmenter;

    localparam int CycleLimit = 400000;
    localparam int IdlePad    = 8;
    localparam int ShowMax    = 10;

    typedef struct packed {
        logic [rprs_pkg::LineW-1:0] run_first;
        logic [rprs_pkg::LineW-1:0] run_last;
        logic [rprs_pkg::RunW-1:0]  run_number;
    } run_item_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rprs_pkg::AddrW-1:0] paddr;
    logic [rprs_pkg::DataW-1:0] pwdata;
    logic [rprs_pkg::DataW-1:0] prdata;
    logic pready;

    rprs_pix_if pix_ch ();
    rprs_run_if run_ch ();

    row_profile_run_segmenter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_ch),
        .run     (run_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of registers and per-scan state
    rprs_pkg::cfg_t             cfg;
    logic [rprs_pkg::CntW-1:0]  line_blacks;
    logic [rprs_pkg::CntW-1:0]  line_pixels;
    logic [rprs_pkg::LineW-1:0] line_no;
    logic                       run_open;
    logic [rprs_pkg::LineW-1:0] run_head;
    logic [rprs_pkg::LineW-1:0] last_dark;
    logic [rprs_pkg::RunW-1:0]  runs_closed;

    run_item_t runs_due[$];
    int runs_predicted = 0;
    int items_sent     = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input run_item_t want, input run_item_t got);
        if (mismatches < ShowMax)
            $display("%0t %s: expected first=%0d last=%0d number=%0d, got first=%0d last=%0d number=%0d",
                     $realtime, what, want.run_first, want.run_last, want.run_number,
                     got.run_first, got.run_last, got.run_number);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_runs
        run_item_t want;
        run_item_t got;
        if (rst_n && run_ch.valid && run_ch.ready)
        begin
            got = '{run_ch.run_first, run_ch.run_last, run_ch.run_number};
            if (runs_due.size() == 0)
                note_mismatch("unexpected run item", '0, got);
            else
            begin
                want = runs_due.pop_front();
                if (got !== want)
                    note_mismatch("run item mismatch", want, got);
            end
        end
        run_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void restart_scan();
        line_blacks = '0;
        line_pixels = '0;
        line_no     = (cfg.start_index > rprs_pkg::LineCap) ? rprs_pkg::LineCap : cfg.start_index;
        run_open    = 1'b0;
        run_head    = '0;
        last_dark   = '0;
        runs_closed = '0;
    endfunction

    function automatic void close_run();
        runs_due.push_back('{run_head, last_dark, runs_closed});
        runs_predicted++;
        if (runs_closed < rprs_pkg::RunCap)
            runs_closed = runs_closed + 1'b1;
        run_open = 1'b0;
    endfunction

    function automatic void track_pixel(input logic [rprs_pkg::GrayW-1:0] gray, input logic le,
                                        input logic se);
        logic                      closed;
        logic [rprs_pkg::LhsW-1:0] lhs;
        logic [rprs_pkg::RhsW-1:0] rhs;
        closed = 1'b0;
        if (gray < cfg.black_threshold && line_blacks < rprs_pkg::CntCap)
            line_blacks = line_blacks + 1'b1;
        if (line_pixels < rprs_pkg::CntCap)
            line_pixels = line_pixels + 1'b1;
        if (le || se)
        begin
            lhs = {line_blacks, 8'd0};
            rhs = cfg.fill_fraction_q8 * line_pixels;
            if (lhs > rhs)
            begin
                if (!run_open)
                begin
                    run_open = 1'b1;
                    run_head = line_no;
                end
                last_dark = line_no;
            end
            else if (run_open && line_no >= last_dark && (line_no - last_dark) > cfg.gap_limit)
            begin
                close_run();
                closed = 1'b1;
            end
            line_blacks = '0;
            line_pixels = '0;
            if (line_no < rprs_pkg::LineCap)
                line_no = line_no + 1'b1;
        end
        if (se)
        begin
            if (run_open && !closed)
                close_run();
            restart_scan();
        end
    endfunction

    task automatic send_pixel(input logic [rprs_pkg::GrayW-1:0] gray, input logic le,
                              input logic se);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            pix_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel_gray <= gray;
        pix_ch.line_end   <= le;
        pix_ch.scan_end   <= se;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        track_pixel(gray, le, se);
        items_sent++;
    endtask

    // n pixels of one gray; marks go on the last one
    task automatic send_span(input int n, input logic [rprs_pkg::GrayW-1:0] gray, input logic le,
                             input logic se);
        for (int k = 0; k < n; k++)
            send_pixel(gray, le && k == n - 1, se && k == n - 1);
    endtask

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge clk);
        repeat (IdlePad) @(posedge clk);
    endtask

    task automatic write_reg(input rprs_pkg::reg_idx_t idx,
                             input logic [rprs_pkg::DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rprs_pkg::REG_BLACK_THRESHOLD:
                cfg.black_threshold  = value[rprs_pkg::GrayW-1:0];
            rprs_pkg::REG_FILL_FRACTION:
                cfg.fill_fraction_q8 = value[rprs_pkg::FillW-1:0];
            rprs_pkg::REG_GAP_LIMIT:
                cfg.gap_limit        = value[rprs_pkg::LineW-1:0];
            rprs_pkg::REG_START_INDEX:
                cfg.start_index      = value[rprs_pkg::LineW-1:0];
            default: ;
        endcase
    endtask

    task automatic program_config(input rprs_pkg::cfg_t c);
        wait_drained();
        write_reg(rprs_pkg::REG_BLACK_THRESHOLD, rprs_pkg::DataW'(c.black_threshold));
        write_reg(rprs_pkg::REG_FILL_FRACTION, rprs_pkg::DataW'(c.fill_fraction_q8));
        write_reg(rprs_pkg::REG_GAP_LIMIT, rprs_pkg::DataW'(c.gap_limit));
        write_reg(rprs_pkg::REG_START_INDEX, rprs_pkg::DataW'(c.start_index));
    endtask

    function automatic rprs_pkg::cfg_t random_config();
        rprs_pkg::cfg_t c;
        case ($urandom_range(7))
            0:       c.black_threshold = 8'd0;
            1:       c.black_threshold = 8'd255;
            default: c.black_threshold = rprs_pkg::GrayW'($urandom_range(230, 30));
        endcase
        case ($urandom_range(7))
            0:       c.fill_fraction_q8 = 9'd0;
            1:       c.fill_fraction_q8 = 9'd256;
            default: c.fill_fraction_q8 = rprs_pkg::FillW'($urandom_range(200, 30));
        endcase
        c.gap_limit = ($urandom_range(7) == 0) ? 12'd4095
                                               : rprs_pkg::LineW'($urandom_range(3));
        case ($urandom_range(7))
            0:       c.start_index = 12'd4095;
            1:       c.start_index = 12'd0;
            default: c.start_index = rprs_pkg::LineW'($urandom_range(4095));
        endcase
        return c;
    endfunction

    function automatic logic [rprs_pkg::GrayW-1:0] pick_gray(input int black_pct);
        if ($urandom_range(9) == 0)
            return rprs_pkg::GrayW'($urandom_range(255));
        if ($urandom_range(99) < black_pct && cfg.black_threshold != 0)
            return rprs_pkg::GrayW'($urandom_range(cfg.black_threshold - 1, 0));
        return rprs_pkg::GrayW'($urandom_range(255, cfg.black_threshold));
    endfunction

    task automatic send_random_scan();
        int   lines;
        int   width;
        int   ln;
        int   p;
        logic dark;
        logic last_line;
        logic drop_le;
        lines = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(12, 1);
        dark  = 1'($urandom_range(1));
        for (ln = 0; ln < lines; ln++)
        begin
            width = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
            if ($urandom_range(99) < 35)
                dark = !dark;
            last_line = (ln == lines - 1);
            drop_le   = last_line && $urandom_range(4) == 0;
            for (p = 0; p < width; p++)
                send_pixel(pick_gray(dark ? 85 : 10), p == width - 1 && !drop_le,
                           p == width - 1 && last_line);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(20, 1);
        repeat (n)
            send_pixel(rprs_pkg::GrayW'($urandom_range(255)), $urandom_range(3) == 0,
                       $urandom_range(15) == 0);
    endtask

    // reset register values: dark line, gaps within the limit, scan end without line end
    task automatic test_reset_values();
        send_pixel(8'd0, 1'b1, 1'b0);
        send_span(2, 8'd200, 1'b1, 1'b0);
        send_span(3, 8'd127, 1'b1, 1'b0);
        send_pixel(8'd128, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd10, 1'b0, 1'b1);
    endtask

    task automatic test_field_extremes();
        program_config('{8'd255, 9'd0, 12'd0, 12'd0});
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd254, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b0);
        // gap close and scan end on one line
        send_pixel(8'd255, 1'b1, 1'b1);
        program_config('{8'd0, 9'd0, 12'd0, 12'd0});
        send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b1);
        program_config('{8'd255, 9'd256, 12'd4095, 12'd0});
        send_span(2, 8'd0, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b1);
        program_config('{8'd128, 9'd128, 12'd4095, 12'd0});
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd200, 1'b1, 1'b0);
        send_span(2, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd200, 1'b1, 1'b0);
        send_span(3, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd127, 1'b1, 1'b1);
    endtask

    task automatic test_line_saturation();
        program_config('{8'd128, 9'd26, 12'd0, 12'd4093});
        send_pixel(8'd0, 1'b1, 1'b1);
        repeat (5) send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b1);
    endtask

    task automatic test_start_index_mid_scan();
        program_config('{8'd128, 9'd26, 12'd1, 12'd0});
        send_pixel(8'd0, 1'b1, 1'b1);
        send_span(2, 8'd0, 1'b1, 1'b0);
        wait_drained();
        write_reg(rprs_pkg::REG_START_INDEX, rprs_pkg::DataW'(100));
        send_span(2, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b1);
        send_pixel(8'd0, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_idle, input int budget);
        int items_base;
        int runs_base;
        gap_pct   = send_idle;
        stall_pct = recv_idle;
        for (int s = 0; s < 4; s++)
        begin
            program_config(random_config());
            items_base = items_sent;
            runs_base  = runs_predicted;
            while (items_sent - items_base < budget / 4 ||
                   (runs_predicted - runs_base < 4 && items_sent - items_base < budget))
            begin
                if ($urandom_range(99) < 85)
                    send_random_scan();
                else
                    send_noise();
                // hold off until the block has emptied
                if ($urandom_range(7) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pix_ch.valid     <= 1'b0;
        pix_ch.pixel_gray <= '0;
        pix_ch.line_end  <= 1'b0;
        pix_ch.scan_end  <= 1'b0;
        cfg = '{rprs_pkg::BlackThresholdRst, rprs_pkg::FillFractionRst,
                rprs_pkg::GapLimitRst, rprs_pkg::StartIndexRst};
        restart_scan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_line_saturation();
        test_start_index_mid_scan();
        test_random_traffic(0, 0, 400);
        test_random_traffic(78, 0, 400);
        test_random_traffic(0, 78, 400);
        test_random_traffic(10, 10, 400);

        wait_drained();
        if (mismatches == 0 && runs_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
